// ===== rtl/ipal_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package ipal_pkg;

    localparam int ENTRIES_DEFAULT = 8;
    localparam int OP_W            = 2;
    localparam int ADDR_W          = 64;
    localparam int IN_TDATA_W      = 136;
    localparam int OUT_TDATA_W     = 8;

    typedef enum logic [OP_W-1:0] {
        OP_ADD    = 2'd0,
        OP_DEL    = 2'd1,
        OP_LOOKUP = 2'd2
    } op_t;

    typedef struct packed {
        logic rd;
        logic wr;
        logic clr;
    } mem_ctl_t;

    typedef struct packed {
        logic listed;
        logic table_full;
        logic added;
    } result_t;

endpackage
`default_nettype wire

// ===== rtl/ipv6_address_allow_list_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Allow list of up to ENTRIES IPv6 addresses held in a single-port-read RAM with one
// valid flip-flop per entry, all cleared by reset. Requests are handled one at a time.
// An add checks one valid bit per cycle; a delete reads and compares one entry
// per cycle over all entries; a lookup does the same but stops at the first hit.
// Each result is then handed to the output register. A result waiting in the
// output register does not hold off the next request.
module ipv6_address_allow_list_core
    import ipal_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEFAULT
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,  // op[1:0], addr_high[65:2], addr_low[129:66]
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    output logic      [OUT_TDATA_W-1:0] m_axis_tdata   // added[0], table_full[1], listed[2]
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    mem_ctl_t            ctl;
    logic [IDX_W-1:0]    idx;
    logic [IDX_W-1:0]    rd_idx;
    logic [ADDR_W-1:0]   wr_high, wr_low;
    logic [ADDR_W-1:0]   rd_high, rd_low;
    logic                valid_bit;
    result_t             res;
    logic                res_valid;
    logic                res_ready;
    logic                out_valid_reg, out_valid_next;
    result_t             out_res_reg, out_res_next;

    ipal_seq #(
        .ENTRIES (ENTRIES),
        .IDX_W   (IDX_W)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_op     (s_axis_tdata[OP_W-1:0]),
        .in_high   (s_axis_tdata[OP_W+ADDR_W-1:OP_W]),
        .in_low    (s_axis_tdata[OP_W+2*ADDR_W-1:OP_W+ADDR_W]),
        .res       (res),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .ctl       (ctl),
        .idx       (idx),
        .rd_idx    (rd_idx),
        .wr_high   (wr_high),
        .wr_low    (wr_low),
        .rd_high   (rd_high),
        .rd_low    (rd_low),
        .valid_bit (valid_bit)
    );

    ipal_store #(
        .ENTRIES (ENTRIES),
        .IDX_W   (IDX_W)
    ) u_store (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .idx       (idx),
        .rd_idx    (rd_idx),
        .wr_high   (wr_high),
        .wr_low    (wr_low),
        .rd_high   (rd_high),
        .rd_low    (rd_low),
        .valid_bit (valid_bit)
    );

    assign res_ready = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_res_next   = out_res_reg;
        if (res_valid && res_ready)
        begin
            out_valid_next = 1'b1;
            out_res_next   = res;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_res_reg <= out_res_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {(OUT_TDATA_W - 3)'(0), out_res_reg.listed,
                            out_res_reg.table_full, out_res_reg.added};

endmodule
`default_nettype wire

// ===== rtl/ipal_store.sv =====
`timescale 1ns / 1ps
`default_nettype none
module ipal_store
    import ipal_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEFAULT,
    parameter int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire mem_ctl_t           ctl,
    input  wire logic [IDX_W-1:0]   idx,
    input  wire logic [IDX_W-1:0]   rd_idx,
    input  wire logic [ADDR_W-1:0]  wr_high,
    input  wire logic [ADDR_W-1:0]  wr_low,
    output logic      [ADDR_W-1:0]  rd_high,
    output logic      [ADDR_W-1:0]  rd_low,
    output logic                    valid_bit
);

    logic [2*ADDR_W-1:0] entry_mem [ENTRIES];
    logic [2*ADDR_W-1:0] rd_data_reg;
    logic [ENTRIES-1:0]  valid_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr)
        begin
            entry_mem[idx] <= {wr_high, wr_low};
        end
        if (ctl.rd)
        begin
            rd_data_reg <= entry_mem[rd_idx];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (ctl.wr)
        begin
            valid_reg[idx] <= 1'b1;
        end
        else if (ctl.clr)
        begin
            valid_reg[idx] <= 1'b0;
        end
    end

    assign rd_high   = rd_data_reg[2*ADDR_W-1:ADDR_W];
    assign rd_low    = rd_data_reg[ADDR_W-1:0];
    assign valid_bit = valid_reg[idx];

endmodule
`default_nettype wire

// ===== rtl/ipal_seq.sv =====
`timescale 1ns / 1ps
`default_nettype none
module ipal_seq
    import ipal_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEFAULT,
    parameter int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [OP_W-1:0]    in_op,
    input  wire logic [ADDR_W-1:0]  in_high,
    input  wire logic [ADDR_W-1:0]  in_low,
    output result_t                 res,
    output logic                    res_valid,
    input  wire logic               res_ready,
    output mem_ctl_t                ctl,
    output logic      [IDX_W-1:0]   idx,
    output logic      [IDX_W-1:0]   rd_idx,
    output logic      [ADDR_W-1:0]  wr_high,
    output logic      [ADDR_W-1:0]  wr_low,
    input  wire logic [ADDR_W-1:0]  rd_high,
    input  wire logic [ADDR_W-1:0]  rd_low,
    input  wire logic               valid_bit
);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_ADD    = 4'b0010,
        S_SEARCH = 4'b0100,
        S_DONE   = 4'b1000
    } state_t;

    state_t              state_reg, state_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [IDX_W-1:0]    idx_plus;
    logic [OP_W-1:0]     op_reg, op_next;
    logic [ADDR_W-1:0]   high_reg, high_next;
    logic [ADDR_W-1:0]   low_reg, low_next;
    result_t             res_reg, res_next;
    logic                match;

    assign idx_plus = IDX_W'(idx_reg + 1'b1);
    assign match    = valid_bit && (rd_high == high_reg) && (rd_low == low_reg);

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        op_next    = op_reg;
        high_next  = high_reg;
        low_next   = low_reg;
        res_next   = res_reg;
        ctl        = '0;
        in_ready   = 1'b0;
        res_valid  = 1'b0;
        rd_idx     = idx_plus;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                rd_idx   = '0;
                if (in_valid)
                begin
                    op_next   = in_op;
                    high_next = in_high;
                    low_next  = in_low;
                    idx_next  = '0;
                    res_next  = '0;
                    case (in_op)
                        OP_ADD:
                        begin
                            state_next = S_ADD;
                        end
                        OP_DEL, OP_LOOKUP:
                        begin
                            ctl.rd     = 1'b1;
                            state_next = S_SEARCH;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_ADD:
            begin
                if (!valid_bit)
                begin
                    ctl.wr         = 1'b1;
                    res_next.added = 1'b1;
                    state_next     = S_DONE;
                end
                else if (idx_reg == LAST_IDX)
                begin
                    res_next.table_full = 1'b1;
                    state_next          = S_DONE;
                end
                else
                begin
                    idx_next = idx_plus;
                end
            end
            S_SEARCH:
            begin
                if (match && (op_reg == OP_DEL))
                begin
                    ctl.clr = 1'b1;
                end
                if (match && (op_reg == OP_LOOKUP))
                begin
                    res_next.listed = 1'b1;
                    state_next      = S_DONE;
                end
                else if (idx_reg == LAST_IDX)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    ctl.rd   = 1'b1;
                    idx_next = idx_plus;
                end
            end
            S_DONE:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        high_reg <= high_next;
        low_reg  <= low_next;
        res_reg  <= res_next;
    end

    assign res     = res_reg;
    assign idx     = idx_reg;
    assign wr_high = high_reg;
    assign wr_low  = low_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        !(ctl.wr && (ctl.clr || ctl.rd)))
        else $error("entry write overlaps another store access");

    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> !(res.added && res.table_full))
        else $error("add reported both stored and full");

    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("new request taken while one is in progress");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SEARCH) |-> $past(ctl.rd))
        else $error("compare without a read issued the cycle before");

endmodule
`default_nettype wire

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
    import ipal_pkg::*;

    localparam int                CYCLE_LIMIT   = 300000;
    localparam int                POOL_SIZE     = 10;
    localparam int                RANDOM_ITEMS  = 630;
    localparam logic [OP_W-1:0]   OP_UNUSED     = 2'd3;
    localparam logic [ADDR_W-1:0] ADDR_ZERO     = '0;
    localparam logic [ADDR_W-1:0] ADDR_ONES     = '1;
    localparam logic [ADDR_W-1:0] DOC_PREFIX    = 64'h2001_0db8_0000_0000;
    localparam logic [ADDR_W-1:0] LINK_PREFIX   = 64'hfe80_0000_0000_0000;
    localparam logic [ADDR_W-1:0] MCAST_PREFIX  = 64'hff02_0000_0000_0000;
    localparam logic [ADDR_W-1:0] PATTERN_5     = 64'h5555_5555_5555_5555;
    localparam logic [ADDR_W-1:0] PATTERN_A     = 64'haaaa_aaaa_aaaa_aaaa;
    localparam int                READY_ALWAYS  = 0;
    localparam int                READY_PATTERN = 1;
    localparam int                READY_SPARSE  = 2;

    logic                   clk           = 1'b0;
    logic                   rst_n         = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    logic [ADDR_W-1:0] entry_high [ENTRIES_DEFAULT];
    logic [ADDR_W-1:0] entry_low  [ENTRIES_DEFAULT];
    logic              entry_used [ENTRIES_DEFAULT];
    result_t           pending_results [$];
    result_t           want;
    result_t           got;
    int                mismatch_count = 0;
    int                cycles         = 0;
    int                burst_left     = 0;
    int                phase_left     = 0;
    int                ready_mode     = READY_ALWAYS;
    logic [31:0]       stall_pattern  = '0;

    ipv6_address_allow_list_core #(
        .ENTRIES(ENTRIES_DEFAULT)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic result_t allow_list_apply(input logic [OP_W-1:0] op,
                                                 input logic [ADDR_W-1:0] hi,
                                                 input logic [ADDR_W-1:0] lo);
        result_t r;
        r = '0;
        if (op == OP_ADD)
        begin
            r.table_full = 1'b1;
            for (int k = 0; k < ENTRIES_DEFAULT; k++)
            begin
                if (!entry_used[k])
                begin
                    entry_used[k] = 1'b1;
                    entry_high[k] = hi;
                    entry_low[k]  = lo;
                    r.added       = 1'b1;
                    r.table_full  = 1'b0;
                    break;
                end
            end
        end
        else if (op == OP_DEL)
        begin
            for (int k = 0; k < ENTRIES_DEFAULT; k++)
            begin
                if (entry_used[k] && entry_high[k] == hi && entry_low[k] == lo)
                    entry_used[k] = 1'b0;
            end
        end
        else if (op == OP_LOOKUP)
        begin
            for (int k = 0; k < ENTRIES_DEFAULT; k++)
            begin
                if (entry_used[k] && entry_high[k] == hi && entry_low[k] == lo)
                    r.listed = 1'b1;
            end
        end
        return r;
    endfunction

    task automatic send_request(input logic [OP_W-1:0] op,
                                input logic [ADDR_W-1:0] hi,
                                input logic [ADDR_W-1:0] lo);
        int gap;
        bit taken;
        if (burst_left == 0)
        begin
            gap        = $urandom_range(1, 6);
            burst_left = $urandom_range(1, 30);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(IN_TDATA_W - OP_W - 2 * ADDR_W){1'b0}}, lo, hi, op};
        do
        begin
            @(negedge clk);
            taken = s_axis_tready;
            @(posedge clk);
        end
        while (!taken);
        pending_results.push_back(allow_list_apply(op, hi, lo));
    endtask

    task automatic wait_drained();
        burst_left = 0;
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending_results.size() != 0);
    endtask

    // Fill every entry, then overflow.
    task automatic test_fill_and_overflow();
        send_request(OP_ADD, ADDR_ZERO, ADDR_ZERO);
        send_request(OP_ADD, ADDR_ONES, ADDR_ONES);
        send_request(OP_ADD, ADDR_ONES, ADDR_ZERO);
        send_request(OP_ADD, ADDR_ZERO, ADDR_ONES);
        send_request(OP_ADD, PATTERN_5, PATTERN_A);
        send_request(OP_ADD, PATTERN_A, PATTERN_5);
        send_request(OP_ADD, DOC_PREFIX, 64'h1);
        send_request(OP_ADD, LINK_PREFIX, 64'h1);
        send_request(OP_ADD, MCAST_PREFIX, 64'h1);
        wait_drained();
    endtask

    task automatic test_lookup_hit_and_miss();
        send_request(OP_LOOKUP, ADDR_ONES, ADDR_ONES);
        send_request(OP_LOOKUP, ADDR_ZERO, ADDR_ZERO);
        send_request(OP_LOOKUP, DOC_PREFIX, 64'h3);
        send_request(OP_LOOKUP, {1'b0, ADDR_ONES[ADDR_W-2:0]}, ADDR_ONES);
    endtask

    task automatic test_delete_and_duplicates();
        send_request(OP_DEL, MCAST_PREFIX, 64'h1);
        send_request(OP_DEL, ADDR_ONES, ADDR_ZERO);
        send_request(OP_LOOKUP, ADDR_ONES, ADDR_ZERO);
        send_request(OP_ADD, DOC_PREFIX, 64'h1);
        send_request(OP_DEL, DOC_PREFIX, 64'h1);
        send_request(OP_LOOKUP, DOC_PREFIX, 64'h1);
        send_request(OP_ADD, LINK_PREFIX, 64'h1);
    endtask

    task automatic test_unused_op();
        send_request(OP_UNUSED, ADDR_ONES, ADDR_ONES);
        send_request(OP_LOOKUP, ADDR_ONES, ADDR_ONES);
        send_request(OP_UNUSED, ADDR_ZERO, ADDR_ZERO);
        wait_drained();
    endtask

    // Draw mostly from a small address pool so adds, deletes and lookups collide.
    task automatic test_random_traffic(input int count);
        logic [ADDR_W-1:0] pool_high [POOL_SIZE];
        logic [ADDR_W-1:0] pool_low  [POOL_SIZE];
        logic [OP_W-1:0]   op;
        logic [ADDR_W-1:0] hi;
        logic [ADDR_W-1:0] lo;
        int                pick;
        int                roll;
        int                flip;
        for (int p = 0; p < POOL_SIZE; p++)
        begin
            pool_high[p] = {$urandom, $urandom};
            pool_low[p]  = {$urandom, $urandom};
        end
        for (int n = 0; n < count; n++)
        begin
            if (n % 80 == 79)
            begin
                pick            = $urandom_range(0, POOL_SIZE - 1);
                pool_high[pick] = {$urandom, $urandom};
                pool_low[pick]  = {$urandom, $urandom};
            end
            if (n == count / 2)
                wait_drained();
            roll = $urandom_range(0, 99);
            if (roll < 38)
                op = OP_ADD;
            else if (roll < 58)
                op = OP_DEL;
            else if (roll < 95)
                op = OP_LOOKUP;
            else
                op = OP_UNUSED;
            pick = $urandom_range(0, POOL_SIZE - 1);
            hi   = pool_high[pick];
            lo   = pool_low[pick];
            roll = $urandom_range(0, 99);
            if (roll < 10)
            begin
                hi = {$urandom, $urandom};
                lo = {$urandom, $urandom};
            end
            else if (roll < 20)
            begin
                flip = $urandom_range(0, 2 * ADDR_W - 1);
                if (flip < ADDR_W)
                    hi[flip] = ~hi[flip];
                else
                    lo[flip - ADDR_W] = ~lo[flip - ADDR_W];
            end
            send_request(op, hi, lo);
        end
    endtask

    always @(posedge clk)
    begin
        if (phase_left == 0)
        begin
            phase_left    <= $urandom_range(16, 96);
            ready_mode    <= $urandom_range(READY_ALWAYS, READY_SPARSE);
            stall_pattern <= $urandom;
        end
        else
        begin
            phase_left <= phase_left - 1;
        end
        case (ready_mode)
            READY_ALWAYS:  m_axis_tready <= 1'b1;
            READY_PATTERN: m_axis_tready <= stall_pattern[phase_left[4:0]];
            default:       m_axis_tready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    function automatic void check_field(input string name, input logic exp, input logic act);
        if (act !== exp)
        begin
            $display("%0t: %s expected %0b actual %0b", $time, name, exp, act);
            mismatch_count++;
        end
    endfunction

    always @(negedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = result_t'(m_axis_tdata[2:0]);
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result expected none actual %b", $time, got);
                mismatch_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("added", want.added, got.added);
                check_field("table_full", want.table_full, got.table_full);
                check_field("listed", want.listed, got.listed);
            end
        end
    end

    initial
    begin
        for (int k = 0; k < ENTRIES_DEFAULT; k++)
            entry_used[k] = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_fill_and_overflow();
        test_lookup_hit_and_miss();
        test_delete_and_duplicates();
        test_unused_op();
        test_random_traffic(RANDOM_ITEMS);
        wait_drained();
        repeat (40) @(posedge clk);
        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/ipal_pkg.sv
rtl/ipal_store.sv
rtl/ipal_seq.sv
rtl/ipv6_address_allow_list_core.sv
test/tb_top.sv
